### src/ptt_pkg.sv
// Shared types and codes for the periodic timer table.
`timescale 1ns / 1ps
`default_nettype none
package ptt_pkg;

  localparam int unsigned REQ_W  = 2;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned ACT_W  = 5;
  localparam int unsigned KIND_W = 2;

  localparam logic [REQ_W-1:0] REQ_ADD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FLAG = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

  localparam logic [KIND_W-1:0] RK_ADD_ACK  = 2'd0;
  localparam logic [KIND_W-1:0] RK_FIRE     = 2'd1;
  localparam logic [KIND_W-1:0] RK_SUMMARY  = 2'd2;
  localparam logic [KIND_W-1:0] RK_FLAG_ACK = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_SUM  = 4'b1000
  } state_t;

endpackage
`default_nettype wire

### src/ptt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ptt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/periodic_timer_table.sv
// Periodic timer table: add, tick walk and deactivate flag over a timer store.
//
// One input channel (in_valid/in_ready) carries requests: add a timer, tick
// with the current time, or write a timer's deactivated flag. One result
// channel (out_valid/out_ready) returns beats; every request but the unused
// code gives at least one, and the final beat of a request has
// out_last_of_run set. Add and flag requests answer in the cycle after
// acceptance. A tick walks the stored timers with one 33-bit adder and
// comparator fed from a single RAM read port: a deactivated timer is skipped
// without a read, an active one is read and then compared, and a summary
// beat closes the walk.
// in_ready is low while a tick walks and while a result beat waits.
// A stalled receiver holds the walk at the timer that is due to fire; no beat
// is lost. Reset empties the table and clears every deactivated flag;
// stored periods and times are not cleared and are only read once written.
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_table #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ptt_pkg::REQ_W-1:0]   in_req_type,
  input  wire logic [ptt_pkg::TIME_W-1:0]  in_period_ms,
  input  wire logic [ptt_pkg::TIME_W-1:0]  in_time_ms,
  input  wire logic [ptt_pkg::IDX_W-1:0]   in_entry_index,
  input  wire logic                        in_deactivate,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [ptt_pkg::KIND_W-1:0]  out_result_kind,
  output logic      [ptt_pkg::IDX_W-1:0]   out_index_out,
  output logic      [ptt_pkg::ACT_W-1:0]   out_active_count,
  output logic                             out_table_full,
  output logic                             out_last_of_run
);

  localparam int unsigned AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW    = (CNT_W > ptt_pkg::IDX_W) ? CNT_W : ptt_pkg::IDX_W;
  localparam int unsigned TW    = ptt_pkg::TIME_W;

  ptt_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       walk_r, walk_nxt;
  logic [CNT_W-1:0]       act_r, act_nxt;
  logic [TW-1:0]          now_r, now_nxt;
  logic [MAX_ENTRIES-1:0] deact_r, deact_nxt;

  logic                         out_valid_r;
  logic [ptt_pkg::KIND_W-1:0]   kind_r;
  logic [ptt_pkg::IDX_W-1:0]    index_r;
  logic [ptt_pkg::ACT_W-1:0]    count_r;
  logic                         full_r;
  logic                         last_r;

  logic                         ld;
  logic [ptt_pkg::KIND_W-1:0]   ld_kind;
  logic [ptt_pkg::IDX_W-1:0]    ld_index;
  logic [ptt_pkg::ACT_W-1:0]    ld_count;
  logic                         ld_full;
  logic                         ld_last;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [2*TW-1:0] ram_wdata;
  logic           ram_re;
  logic [2*TW-1:0] ram_rdata;

  logic           out_free;
  logic           in_fire;
  logic [TW:0]    due_sum;
  logic           due;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ptt_pkg::S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  assign due_sum = {1'b0, ram_rdata[TW-1:0]} + {1'b0, ram_rdata[2*TW-1:TW]};
  assign due     = due_sum < {1'b0, now_r};

  ptt_ram #(
    .WIDTH (2 * TW),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (walk_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    walk_nxt  = walk_r;
    act_nxt   = act_r;
    now_nxt   = now_r;
    deact_nxt = deact_r;
    ld        = 1'b0;
    ld_kind   = ptt_pkg::RK_ADD_ACK;
    ld_index  = '0;
    ld_count  = '0;
    ld_full   = 1'b0;
    ld_last   = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = cnt_r[AW-1:0];
    ram_wdata = {in_period_ms, in_time_ms};
    ram_re    = 1'b0;
    unique case (state_r)
      ptt_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (in_req_type)
            ptt_pkg::REQ_ADD: begin
              ld      = 1'b1;
              ld_kind = ptt_pkg::RK_ADD_ACK;
              if (cnt_r == CNT_W'(MAX_ENTRIES)) begin
                ld_full = 1'b1;
              end else begin
                ram_we                    = 1'b1;
                deact_nxt[cnt_r[AW-1:0]]  = 1'b0;
                ld_index                  = ptt_pkg::IDX_W'(cnt_r);
                cnt_nxt                   = cnt_r + 1'b1;
              end
            end
            ptt_pkg::REQ_TICK: begin
              now_nxt   = in_time_ms;
              walk_nxt  = '0;
              act_nxt   = '0;
              state_nxt = ptt_pkg::S_RD;
            end
            ptt_pkg::REQ_FLAG: begin
              ld       = 1'b1;
              ld_kind  = ptt_pkg::RK_FLAG_ACK;
              ld_index = in_entry_index;
              if (CW'(in_entry_index) < CW'(cnt_r)) begin
                deact_nxt[AW'(in_entry_index)] = in_deactivate;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ptt_pkg::S_RD: begin
        if (walk_r == cnt_r) begin
          state_nxt = ptt_pkg::S_SUM;
        end else if (deact_r[walk_r[AW-1:0]]) begin
          walk_nxt = walk_r + 1'b1;
        end else begin
          ram_re    = 1'b1;
          act_nxt   = act_r + 1'b1;
          state_nxt = ptt_pkg::S_CMP;
        end
      end
      ptt_pkg::S_CMP: begin
        if (!due) begin
          walk_nxt  = walk_r + 1'b1;
          state_nxt = ptt_pkg::S_RD;
        end else if (out_free) begin
          ld        = 1'b1;
          ld_kind   = ptt_pkg::RK_FIRE;
          ld_index  = ptt_pkg::IDX_W'(walk_r);
          ld_last   = 1'b0;
          ram_we    = 1'b1;
          ram_waddr = walk_r[AW-1:0];
          ram_wdata = {ram_rdata[2*TW-1:TW], now_r};
          walk_nxt  = walk_r + 1'b1;
          state_nxt = ptt_pkg::S_RD;
        end
      end
      ptt_pkg::S_SUM: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_kind   = ptt_pkg::RK_SUMMARY;
          ld_count  = ptt_pkg::ACT_W'(act_r);
          state_nxt = ptt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ptt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptt_pkg::S_IDLE;
      cnt_r       <= '0;
      walk_r      <= '0;
      act_r       <= '0;
      deact_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      walk_r  <= walk_nxt;
      act_r   <= act_nxt;
      deact_r <= deact_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    if (ld) begin
      kind_r  <= ld_kind;
      index_r <= ld_index;
      count_r <= ld_count;
      full_r  <= ld_full;
      last_r  <= ld_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = kind_r;
  assign out_index_out    = index_r;
  assign out_active_count = count_r;
  assign out_table_full   = full_r;
  assign out_last_of_run  = last_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ptt_pkg::S_IDLE) |-> (walk_r <= cnt_r) && (act_r <= walk_r + 1'b1))
    else $error("walk index beyond entry count");

  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_req_type == ptt_pkg::REQ_TICK) |=>
      (state_r == ptt_pkg::S_RD) && (walk_r == '0) && (act_r == '0))
    else $error("tick walk did not start from the first entry");

  a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == ptt_pkg::RK_FIRE) |-> !out_last_of_run)
    else $error("fire beat marked as last");

  a_write_with_beat: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ld && out_free)
    else $error("store written without a result beat");
`endif

endmodule
`default_nettype wire
